>>> rtl/core/bas_pkg.sv
// ----------------------------------------------------------------------------
// Block Adler-32 signer package
// Constants and the queue word type shared by the signer's front, queue and
// back modules.
// ----------------------------------------------------------------------------
package bas_pkg;

	localparam int DATA_W      = 8;
	localparam int LEN_W       = 25;
	localparam int NUM_W       = 24;
	localparam int OFFSET_W    = 48;
	localparam int SUM_W       = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [SUM_W:0]    ADLER_MOD        = 17'd65521;
	localparam logic [SUM_W-1:0]  SUM_LOW_RESET    = 16'd1;
	localparam logic [LEN_W-1:0]  MAX_BLOCK        = 25'd16777216;
	localparam logic [LEN_W-1:0]  BLOCK_SIZE_RESET = 25'd65536;
	localparam logic [NUM_W-1:0]  NUM_MAX          = 24'hFFFFFF;

	// One queued word: a file byte plus what the front learned about it.
	typedef struct packed {
		logic [DATA_W-1:0] data_byte;
		logic              eof;
		logic              close;
		logic [LEN_W-1:0]  len;
	} item_t;

endpackage

>>> rtl/core/bas_front.sv
// ----------------------------------------------------------------------------
// Block Adler-32 signer front
// Holds the block size register, counts bytes within the current block and
// marks each byte that closes a block.
// ----------------------------------------------------------------------------
module bas_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bas_pkg::LEN_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bas_pkg::DATA_W-1:0]    data_byte,
	input  logic                          end_of_file,
	output logic                          push_valid,
	input  logic                          push_ready,
	output bas_pkg::item_t                push_item
);

	logic [bas_pkg::LEN_W-1:0] size_q;
	logic [bas_pkg::LEN_W-1:0] count_q;
	logic [bas_pkg::LEN_W-1:0] len;
	logic                      close;
	logic                      accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = push_ready;
	assign accept    = in_valid && push_ready;

	// The register holds the size already clamped to the legal range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= bas_pkg::BLOCK_SIZE_RESET;
		end else if (cfg_valid) begin
			if (cfg_data == '0) begin
				size_q <= bas_pkg::LEN_W'(1);
			end else if (cfg_data > bas_pkg::MAX_BLOCK) begin
				size_q <= bas_pkg::MAX_BLOCK;
			end else begin
				size_q <= cfg_data;
			end
		end
	end

	always_comb begin
		len   = (count_q < bas_pkg::MAX_BLOCK) ? count_q + bas_pkg::LEN_W'(1) : count_q;
		close = end_of_file || (len >= size_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= close ? '0 : len;
		end
	end

	assign push_valid          = in_valid;
	assign push_item.data_byte = data_byte;
	assign push_item.eof       = end_of_file;
	assign push_item.close     = close;
	assign push_item.len       = len;

endmodule

>>> rtl/core/bas_queue.sv
// ----------------------------------------------------------------------------
// Block Adler-32 signer queue
// Small first-in first-out buffer of classified words between front and back.
// ----------------------------------------------------------------------------
module bas_queue #(
	parameter int DEPTH = bas_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push_valid,
	output logic                          push_ready,
	input  bas_pkg::item_t                push_item,
	output logic                          pop_valid,
	input  logic                          pop_ready,
	output bas_pkg::item_t                pop_item,
	output logic [$clog2(DEPTH+1)-1:0]    count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bas_pkg::item_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];
	assign count      = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/core/bas_back.sv
// ----------------------------------------------------------------------------
// Block Adler-32 signer back
// Runs the two Adler-32 sums over queued bytes, tracks block index and file
// offset, and holds each finished block's result in the output register.
// ----------------------------------------------------------------------------
module bas_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pop_valid,
	output logic                            pop_ready,
	input  bas_pkg::item_t                  pop_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bas_pkg::NUM_W-1:0]       block_number,
	output logic [bas_pkg::OFFSET_W-1:0]    block_start,
	output logic [bas_pkg::LEN_W-1:0]       block_length,
	output logic [2*bas_pkg::SUM_W-1:0]     weak_checksum,
	output logic                            final_block
);

	logic [bas_pkg::SUM_W-1:0]    sum_low_q;
	logic [bas_pkg::SUM_W-1:0]    sum_high_q;
	logic [bas_pkg::NUM_W-1:0]    counter_q;
	logic [bas_pkg::OFFSET_W-1:0] offset_q;
	logic                         out_valid_q;
	logic [bas_pkg::NUM_W-1:0]    number_q;
	logic [bas_pkg::OFFSET_W-1:0] start_q;
	logic [bas_pkg::LEN_W-1:0]    length_q;
	logic [2*bas_pkg::SUM_W-1:0]  checksum_q;
	logic                         final_q;

	logic [bas_pkg::SUM_W:0]      low_sum;
	logic [bas_pkg::SUM_W:0]      high_sum;
	logic [bas_pkg::SUM_W-1:0]    low_next;
	logic [bas_pkg::SUM_W-1:0]    high_next;
	logic                         take;
	logic                         emit;

	// A word that closes no block never needs the output register.
	assign pop_ready = !pop_item.close || !out_valid_q || out_ready;
	assign take      = pop_valid && pop_ready;
	assign emit      = take && pop_item.close;

	// Both sums stay below the modulus, so one conditional subtract suffices.
	always_comb begin
		low_sum   = {1'b0, sum_low_q} + (bas_pkg::SUM_W+1)'(pop_item.data_byte);
		low_next  = (low_sum >= bas_pkg::ADLER_MOD) ?
			bas_pkg::SUM_W'(low_sum - bas_pkg::ADLER_MOD) : low_sum[bas_pkg::SUM_W-1:0];
		high_sum  = {1'b0, sum_high_q} + {1'b0, low_next};
		high_next = (high_sum >= bas_pkg::ADLER_MOD) ?
			bas_pkg::SUM_W'(high_sum - bas_pkg::ADLER_MOD) : high_sum[bas_pkg::SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_low_q  <= bas_pkg::SUM_LOW_RESET;
			sum_high_q <= '0;
			counter_q  <= '0;
			offset_q   <= '0;
		end else if (take) begin
			if (pop_item.close) begin
				sum_low_q  <= bas_pkg::SUM_LOW_RESET;
				sum_high_q <= '0;
				if (pop_item.eof) begin
					counter_q <= '0;
					offset_q  <= '0;
				end else begin
					if (counter_q != bas_pkg::NUM_MAX) begin
						counter_q <= counter_q + bas_pkg::NUM_W'(1);
					end
					offset_q <= offset_q + bas_pkg::OFFSET_W'(pop_item.len);
				end
			end else begin
				sum_low_q  <= low_next;
				sum_high_q <= high_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			number_q   <= counter_q;
			start_q    <= offset_q;
			length_q   <= pop_item.len;
			checksum_q <= {high_next, low_next};
			final_q    <= pop_item.eof;
		end
	end

	assign out_valid     = out_valid_q;
	assign block_number  = number_q;
	assign block_start   = start_q;
	assign block_length  = length_q;
	assign weak_checksum = checksum_q;
	assign final_block   = final_q;

endmodule

>>> rtl/core/block_adler32_signer_core.sv
// ----------------------------------------------------------------------------
// Block Adler-32 signer core
// Path: the byte that closes a block passes through the queue, and its result word is held in the output register.
// Throughput: one byte per cycle while the queue has room; a result word held at the output can stall it.
// Reset: asynchronous; block size returns to 65536, the low sum returns to one, the high sum and counters clear.
// ----------------------------------------------------------------------------
module block_adler32_signer_core #(
	parameter int QUEUE_DEPTH = bas_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bas_pkg::LEN_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bas_pkg::DATA_W-1:0]      data_byte,
	input  logic                            end_of_file,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bas_pkg::NUM_W-1:0]       block_number,
	output logic [bas_pkg::OFFSET_W-1:0]    block_start,
	output logic [bas_pkg::LEN_W-1:0]       block_length,
	output logic [2*bas_pkg::SUM_W-1:0]     weak_checksum,
	output logic                            final_block
);

	bas_pkg::item_t                     push_item;
	bas_pkg::item_t                     pop_item;
	logic                               push_valid;
	logic                               push_ready;
	logic                               pop_valid;
	logic                               pop_ready;
	logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count;

	bas_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.end_of_file(end_of_file),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	bas_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.count     (q_count)
	);

	bas_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.block_number (block_number),
		.block_start  (block_start),
		.block_length (block_length),
		.weak_checksum(weak_checksum),
		.final_block  (final_block)
	);

	// A result word never carries an empty or oversized block.
	a_length_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (block_length != '0) && (block_length <= bas_pkg::MAX_BLOCK))
		else $error("block length out of range");

	// Both checksum halves stay reduced below the modulus.
	a_sums_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, weak_checksum[15:0]} < bas_pkg::ADLER_MOD) &&
			({1'b0, weak_checksum[31:16]} < bas_pkg::ADLER_MOD))
		else $error("checksum half not reduced");

	// An accepted byte always lands in the queue.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (q_count != '0))
		else $error("accepted word missing from queue");

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// Block Adler-32 signer testbench
// Streams files of random bytes through the signer under a range of block
// sizes. Block signatures are predicted as each byte word is accepted, and
// every result word is checked field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF    = 6;
	localparam int RESET_CYCLES = 7;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 50;
	localparam int NUM_PHASES  = 12;

	typedef struct packed {
		logic [bas_pkg::DATA_W-1:0] data;
		logic                       eof;
	} file_byte_t;

	typedef struct packed {
		logic [bas_pkg::NUM_W-1:0]     num;
		logic [bas_pkg::OFFSET_W-1:0]  start;
		logic [bas_pkg::LEN_W-1:0]     len;
		logic [2*bas_pkg::SUM_W-1:0]   sum;
		logic                          last;
	} block_sig_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [bas_pkg::LEN_W-1:0]        cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic [bas_pkg::DATA_W-1:0]       data_byte = '0;
	logic                             end_of_file = 1'b0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic [bas_pkg::NUM_W-1:0]        block_number;
	logic [bas_pkg::OFFSET_W-1:0]     block_start;
	logic [bas_pkg::LEN_W-1:0]        block_length;
	logic [2*bas_pkg::SUM_W-1:0]      weak_checksum;
	logic                             final_block;

	// Predictor state: the running sums and counters of the open block.
	logic [bas_pkg::SUM_W-1:0]        adler_a;
	logic [bas_pkg::SUM_W-1:0]        adler_b;
	logic [bas_pkg::LEN_W-1:0]        fill_count;
	logic [bas_pkg::NUM_W-1:0]        next_number;
	logic [bas_pkg::OFFSET_W-1:0]     next_start;
	logic [bas_pkg::LEN_W-1:0]        size_reg;

	file_byte_t              byte_q[$];
	block_sig_t              sig_q[$];

	int                      fail_count = 0;
	int                      blocks_checked = 0;
	int                      files_seen = 0;
	int                      bytes_sent = 0;
	int                      sizes_written = 0;
	int                      cycle_count = 0;
	bit                      jitter_on = 1'b1;

	block_adler32_signer_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_file   (end_of_file),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.block_number  (block_number),
		.block_start   (block_start),
		.block_length  (block_length),
		.weak_checksum (weak_checksum),
		.final_block   (final_block)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Zero and oversized settings are clamped into the legal block range.
	function automatic logic [bas_pkg::LEN_W-1:0] active_size();
		if (size_reg == '0) begin
			return bas_pkg::LEN_W'(1);
		end
		if (size_reg > bas_pkg::MAX_BLOCK) begin
			return bas_pkg::MAX_BLOCK;
		end
		return size_reg;
	endfunction

	function automatic void clear_signer_state();
		adler_a     = bas_pkg::SUM_LOW_RESET;
		adler_b     = '0;
		fill_count  = '0;
		next_number = '0;
		next_start  = '0;
	endfunction

	function automatic void sign_byte(input logic [bas_pkg::DATA_W-1:0] b, input logic eof);
		int unsigned a_next;
		int unsigned b_next;
		block_sig_t  sig;
		a_next  = (int'(adler_a) + int'(b)) % int'(bas_pkg::ADLER_MOD);
		b_next  = (int'(adler_b) + a_next) % int'(bas_pkg::ADLER_MOD);
		adler_a = bas_pkg::SUM_W'(a_next);
		adler_b = bas_pkg::SUM_W'(b_next);
		if (fill_count < bas_pkg::MAX_BLOCK) begin
			fill_count++;
		end
		if (eof || fill_count >= active_size()) begin
			sig.num   = next_number;
			sig.start = next_start;
			sig.len   = fill_count;
			sig.sum   = {adler_b, adler_a};
			sig.last  = eof;
			sig_q.push_back(sig);
			adler_a = bas_pkg::SUM_LOW_RESET;
			adler_b = '0;
			if (eof) begin
				next_number = '0;
				next_start  = '0;
				files_seen++;
			end else begin
				if (next_number != bas_pkg::NUM_MAX) begin
					next_number++;
				end
				next_start = next_start + bas_pkg::OFFSET_W'(fill_count);
			end
			fill_count = '0;
		end
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch in %s: got 0x%0h, want 0x%0h", field, got, want);
		fail_count++;
	endtask

	function automatic void push_byte(input logic [bas_pkg::DATA_W-1:0] d, input logic eof);
		byte_q.push_back(file_byte_t'{d, eof});
	endfunction

	// Heavy content is mostly 0xFF so that sum a wraps inside one block.
	function automatic void push_random_file(input int len, input bit heavy, input bit closed);
		logic [bas_pkg::DATA_W-1:0] d;
		for (int i = 0; i < len; i++) begin
			if (heavy) begin
				d = ($urandom_range(0, 3) != 0) ? 8'hFF : 8'($urandom);
			end else if ($urandom_range(0, 7) == 0) begin
				d = 8'hFF;
			end else if ($urandom_range(0, 7) == 0) begin
				d = 8'h00;
			end else begin
				d = 8'($urandom);
			end
			push_byte(d, closed && (i == len - 1));
		end
	endfunction

	// Waits until every byte is taken and every block word has arrived, then
	// lets the pipeline run dry, since an open block produces no word.
	task automatic settle();
		do begin
			@(negedge clk);
		end while (byte_q.size() != 0 || in_valid || sig_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_block_size(input logic [bas_pkg::LEN_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		size_reg = value;
		cfg_valid <= 1'b0;
		sizes_written++;
	endtask

	// Byte side: one word in flight, a random gap drawn after each one.
	always @(posedge clk or negedge arst_n) begin : byte_side
		int         gap_left;
		file_byte_t w;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			data_byte   <= '0;
			end_of_file <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				sign_byte(data_byte, end_of_file);
				bytes_sent++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (byte_q.size() != 0) begin
					w = byte_q.pop_front();
					in_valid    <= 1'b1;
					data_byte   <= w.data;
					end_of_file <= w.eof;
					gap_left = jitter_on ? $urandom_range(0, 4) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result side: checks each block word, then stalls a random while.
	always @(posedge clk or negedge arst_n) begin : sig_side
		int         hold_left;
		block_sig_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (sig_q.size() == 0) begin
					report_mismatch("unexpected word, block_number", 64'(block_number), '0);
				end else begin
					want = sig_q.pop_front();
					if (block_number !== want.num) begin
						report_mismatch("block_number", 64'(block_number), 64'(want.num));
					end
					if (block_start !== want.start) begin
						report_mismatch("block_start", 64'(block_start), 64'(want.start));
					end
					if (block_length !== want.len) begin
						report_mismatch("block_length", 64'(block_length), 64'(want.len));
					end
					if (weak_checksum !== want.sum) begin
						report_mismatch("weak_checksum", 64'(weak_checksum), 64'(want.sum));
					end
					if (final_block !== want.last) begin
						report_mismatch("final_block", 64'(final_block), 64'(want.last));
					end
					blocks_checked++;
				end
				hold_left = jitter_on ? $urandom_range(0, 4) : 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d block words pending", cycle_count,
				sig_q.size());
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		logic [bas_pkg::LEN_W-1:0] phase_sizes[NUM_PHASES];
		int                        left;
		int                        len;
		longint                    lim;
		bit                        open_tail;

		clear_signer_state();
		size_reg = bas_pkg::BLOCK_SIZE_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Short files at the reset block size, including single-byte files.
		@(negedge clk);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h01, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'hAA, 1'b0);
		push_byte(8'h55, 1'b1);

		// A size of zero acts as one: every byte closes its own block.
		settle();
		write_block_size('0);
		@(negedge clk);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h10, 1'b0);
		push_byte(8'h20, 1'b1);

		// Shrinking the size below what the open block holds closes it on
		// the next byte, with the longer length.
		settle();
		write_block_size(bas_pkg::LEN_W'(3));
		@(negedge clk);
		push_byte(8'h33, 1'b0);
		push_byte(8'h99, 1'b0);
		settle();
		write_block_size(bas_pkg::LEN_W'(1));
		@(negedge clk);
		push_byte(8'h44, 1'b0);
		push_byte(8'h77, 1'b1);

		// An all-ones size clamps to the largest block; end of file closes it.
		settle();
		write_block_size('1);
		@(negedge clk);
		push_byte(8'hC3, 1'b0);
		push_byte(8'h3C, 1'b0);
		push_byte(8'h0F, 1'b0);
		push_byte(8'hF0, 1'b1);

		phase_sizes = '{bas_pkg::LEN_W'(65536), bas_pkg::LEN_W'(2), bas_pkg::MAX_BLOCK,
			bas_pkg::LEN_W'(1), '1, '0,
			bas_pkg::LEN_W'(16777215), bas_pkg::LEN_W'(3), bas_pkg::LEN_W'(64),
			bas_pkg::LEN_W'(5), bas_pkg::LEN_W'($urandom_range(4, 40)),
			bas_pkg::LEN_W'(13)};

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			write_block_size(phase_sizes[p]);
			@(negedge clk);
			jitter_on = ($urandom_range(0, 3) != 0);
			open_tail = $urandom_range(0, 1);
			left = PHASE_BYTES;
			while (left > 0) begin
				lim = 3 * longint'(active_size()) + 2;
				if (lim > left) begin
					lim = left;
				end
				len = $urandom_range(1, int'(lim));
				left -= len;
				push_random_file(len, 1'b0, !(left == 0 && open_tail));
			end
		end

		// One long file of mostly 0xFF bytes drives both sums through the modulus.
		settle();
		write_block_size(bas_pkg::LEN_W'(300));
		@(negedge clk);
		jitter_on = 1'b1;
		push_random_file(400, 1'b1, 1'b1);

		settle();
		$display("summary: %0d bytes in %0d files, %0d block words checked",
			bytes_sent, files_seen, blocks_checked);
		$display("summary: %0d block size writes, from zero through all ones", sizes_written);
		if (fail_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/bas_pkg.sv
rtl/core/bas_front.sv
rtl/core/bas_queue.sv
rtl/core/bas_back.sv
rtl/core/block_adler32_signer_core.sv
dv/tb_top.sv
